/* rtl/core/btlv_pkg.sv */
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and constants for the BER-TLV header decoder pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AvailW = 20;
  localparam int unsigned TagNumW = 14;
  localparam int unsigned VlenW  = 16;
  localparam int unsigned EncW   = 17;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_BAD_TAG = 2'd2,
    ST_BAD_LEN = 2'd3
  } status_e;

  // tag class codes
  typedef enum logic [1:0] {
    CLS_UNIVERSAL   = 2'd0,
    CLS_APPLICATION = 2'd1,
    CLS_CONTEXT     = 2'd2,
    CLS_PRIVATE     = 2'd3
  } obj_class_e;

  localparam logic [4:0] TagLongForm = 5'd31;
  localparam logic [6:0] MaxLenOctets = 7'd2;

  // raw window as it enters the pipeline
  typedef struct packed {
    logic [ByteW-1:0]  byte0;
    logic [ByteW-1:0]  byte1;
    logic [ByteW-1:0]  byte2;
    logic [ByteW-1:0]  byte3;
    logic [ByteW-1:0]  byte4;
    logic [ByteW-1:0]  byte5;
    logic [AvailW-1:0] avail;
  } window_t;

  // after tag decode
  typedef struct packed {
    status_e           status;
    logic              tag_ok;
    obj_class_e        obj_class;
    logic              cons;
    logic [TagNumW-1:0] tag_number;
    logic [1:0]        tag_octets;
    logic [ByteW-1:0]  len_b0;
    logic [ByteW-1:0]  len_b1;
    logic [ByteW-1:0]  len_b2;
    logic [AvailW-1:0] avail;
  } tag_stage_t;

  // after length decode
  typedef struct packed {
    status_e           status;
    obj_class_e        obj_class;
    logic              cons;
    logic [TagNumW-1:0] tag_number;
    logic [1:0]        tag_octets;
    logic [1:0]        len_octets;
    logic [VlenW-1:0]  value_length;
    logic              indef;
    logic [AvailW-1:0] avail;
  } len_stage_t;

  // final result
  typedef struct packed {
    status_e           status;
    obj_class_e        obj_class;
    logic              cons;
    logic [TagNumW-1:0] tag_number;
    logic [1:0]        tag_octets;
    logic [VlenW-1:0]  value_length;
    logic              indef;
    logic [EncW-1:0]   encoded_length;
    logic              fits;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/btlv_if.sv */
// ----------------------------------------------------------------------------
// btlv_in_if / btlv_out_if
// Valid/ready channels carrying a header window and a decode result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface btlv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte0;
  logic [7:0]  byte1;
  logic [7:0]  byte2;
  logic [7:0]  byte3;
  logic [7:0]  byte4;
  logic [7:0]  byte5;
  logic [19:0] bytes_available;

  modport source (
    output valid, byte0, byte1, byte2, byte3, byte4, byte5, bytes_available,
    input  ready
  );
  modport sink (
    input  valid, byte0, byte1, byte2, byte3, byte4, byte5, bytes_available,
    output ready
  );
endinterface

interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  obj_class;
  logic        is_constructed;
  logic [13:0] tag_number;
  logic [1:0]  tag_octets;
  logic [15:0] value_length;
  logic        is_indefinite;
  logic [16:0] encoded_length;
  logic        fits_buffer;

  modport source (
    output valid, status, obj_class, is_constructed, tag_number, tag_octets,
           value_length, is_indefinite, encoded_length, fits_buffer,
    input  ready
  );
  modport sink (
    input  valid, status, obj_class, is_constructed, tag_number, tag_octets,
           value_length, is_indefinite, encoded_length, fits_buffer,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/btlv_tag_stage.sv */
// ----------------------------------------------------------------------------
// btlv_tag_stage
// Pipeline stage 1: class check, tag decode and length byte selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_tag_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire btlv_pkg::window_t   data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output btlv_pkg::tag_stage_t     data_o
);
  import btlv_pkg::*;

  tag_stage_t d_s;
  logic       valid_q;
  tag_stage_t data_q;
  logic [4:0] low5;

  assign low5 = data_i.byte0[4:0];

  // tag decode
  always_comb begin
    d_s            = '0;
    d_s.status     = ST_FAIL;
    d_s.obj_class  = obj_class_e'(data_i.byte0[7:6]);
    d_s.cons       = data_i.byte0[5];
    d_s.avail      = data_i.avail;
    if (d_s.obj_class != CLS_PRIVATE) begin
      if (low5 != TagLongForm && data_i.avail != '0) begin
        d_s.tag_octets = 2'd1;
        d_s.tag_number = {{(TagNumW-5){1'b0}}, low5};
      end else if (low5 == TagLongForm && data_i.avail >= AvailW'(2)) begin
        if (!data_i.byte1[7]) begin
          d_s.tag_octets = 2'd2;
          d_s.tag_number = {7'd0, data_i.byte1[6:0]};
        end else if (data_i.avail >= AvailW'(3)) begin
          d_s.tag_octets = 2'd3;
          d_s.tag_number = {data_i.byte1[6:0], data_i.byte2[6:0]};
        end else begin
          d_s.status = ST_BAD_TAG;
        end
      end else begin
        d_s.status = ST_BAD_TAG;
      end
      // tag number zero is rejected and treated as unparsed
      if (d_s.tag_octets != 2'd0 && d_s.tag_number == '0) begin
        d_s.status     = ST_FAIL;
        d_s.tag_octets = 2'd0;
      end
    end
    d_s.tag_ok = (d_s.tag_octets != 2'd0);

    // pick the octets that follow the tag
    case (d_s.tag_octets)
      2'd1: begin
        d_s.len_b0 = data_i.byte1;
        d_s.len_b1 = data_i.byte2;
        d_s.len_b2 = data_i.byte3;
      end
      2'd2: begin
        d_s.len_b0 = data_i.byte2;
        d_s.len_b1 = data_i.byte3;
        d_s.len_b2 = data_i.byte4;
      end
      2'd3: begin
        d_s.len_b0 = data_i.byte3;
        d_s.len_b1 = data_i.byte4;
        d_s.len_b2 = data_i.byte5;
      end
      default: begin
        d_s.len_b0 = '0;
        d_s.len_b1 = '0;
        d_s.len_b2 = '0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= d_s;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/core/btlv_len_stage.sv */
// ----------------------------------------------------------------------------
// btlv_len_stage
// Pipeline stage 2: short, long and indefinite length decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_len_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire btlv_pkg::tag_stage_t data_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output btlv_pkg::len_stage_t      data_o
);
  import btlv_pkg::*;

  len_stage_t        d_s;
  logic              valid_q;
  len_stage_t        data_q;
  logic [AvailW-1:0] need;
  logic [1:0]        n2;

  assign need = AvailW'(data_i.tag_octets) + AvailW'(1);
  assign n2   = data_i.len_b0[1:0];

  // length decode
  always_comb begin
    d_s            = '0;
    d_s.status     = ST_FAIL;
    d_s.obj_class  = data_i.obj_class;
    d_s.cons       = data_i.cons;
    d_s.tag_number = data_i.tag_number;
    d_s.tag_octets = data_i.tag_octets;
    d_s.avail      = data_i.avail;
    if (!data_i.tag_ok) begin
      d_s.status = data_i.status;
    end else if (data_i.avail >= need) begin
      if (!data_i.len_b0[7]) begin
        d_s.value_length = {8'd0, data_i.len_b0};
        d_s.status       = ST_OK;
      end else if (data_i.len_b0[6:0] > MaxLenOctets) begin
        d_s.status = ST_BAD_LEN;
      end else if (data_i.avail < need + AvailW'(n2)) begin
        d_s.status = ST_BAD_LEN;
      end else begin
        d_s.len_octets = n2;
        d_s.status     = ST_OK;
        case (n2)
          2'd0:    d_s.indef = 1'b1;
          2'd1:    d_s.value_length = {8'd0, data_i.len_b1};
          2'd2:    d_s.value_length = {data_i.len_b1, data_i.len_b2};
          default: d_s.status = ST_BAD_LEN;
        endcase
      end
      // primitive objects need a definite length
      if (d_s.status == ST_OK && !data_i.cons && d_s.indef) begin
        d_s.status = ST_BAD_TAG;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= d_s;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/core/btlv_sum_stage.sv */
// ----------------------------------------------------------------------------
// btlv_sum_stage
// Pipeline stage 3: total encoded length and buffer fit check, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module btlv_sum_stage (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire btlv_pkg::len_stage_t data_i,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output btlv_pkg::result_t         data_o
);
  import btlv_pkg::*;

  result_t         d_s;
  logic            valid_q;
  result_t         data_q;
  logic [EncW-1:0] enc;

  assign enc = EncW'(data_i.tag_octets) + EncW'(1) + EncW'(data_i.len_octets)
             + EncW'(data_i.value_length);

  // length sum and fit compare
  always_comb begin
    d_s                = '0;
    d_s.status         = data_i.status;
    d_s.obj_class      = data_i.obj_class;
    d_s.cons           = data_i.cons;
    d_s.tag_number     = data_i.tag_number;
    d_s.tag_octets     = data_i.tag_octets;
    d_s.value_length   = data_i.value_length;
    d_s.indef          = data_i.indef;
    if (data_i.status == ST_OK) begin
      d_s.encoded_length = enc;
      d_s.fits           = (AvailW'(enc) <= data_i.avail);
    end
  end

  assign ready_o = !valid_q || ready_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= d_s;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

/* rtl/core/ber_tlv_header_decoder.sv */
// ----------------------------------------------------------------------------
// ber_tlv_header_decoder
// Decodes class, tag and length of a BER-TLV header from a six-byte window.
// ----------------------------------------------------------------------------
// the window is registered in the tag, length and sum stages in turn
// throughput: one window per cycle without output stalls; each stage holds one
// an output stall reaches the input in the same cycle once all stages hold data
// reset: asynchronous, clears all stage valid bits; payload is not reset
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_header_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  btlv_in_if.sink    in_i,
  btlv_out_if.source out_o
);
  import btlv_pkg::*;

  window_t    win_s;
  logic       tag_valid_s;
  logic       tag_ready_s;
  tag_stage_t tag_data_s;
  logic       len_valid_s;
  logic       len_ready_s;
  len_stage_t len_data_s;
  result_t    res_s;

  // pack the incoming window
  assign win_s.byte0 = in_i.byte0;
  assign win_s.byte1 = in_i.byte1;
  assign win_s.byte2 = in_i.byte2;
  assign win_s.byte3 = in_i.byte3;
  assign win_s.byte4 = in_i.byte4;
  assign win_s.byte5 = in_i.byte5;
  assign win_s.avail = in_i.bytes_available;

  btlv_tag_stage u_tag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (win_s),
    .valid_o (tag_valid_s),
    .ready_i (tag_ready_s),
    .data_o  (tag_data_s)
  );

  btlv_len_stage u_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (tag_valid_s),
    .ready_o (tag_ready_s),
    .data_i  (tag_data_s),
    .valid_o (len_valid_s),
    .ready_i (len_ready_s),
    .data_o  (len_data_s)
  );

  btlv_sum_stage u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (len_valid_s),
    .ready_o (len_ready_s),
    .data_i  (len_data_s),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res_s)
  );

  // unpack the result
  assign out_o.status         = res_s.status;
  assign out_o.obj_class      = res_s.obj_class;
  assign out_o.is_constructed = res_s.cons;
  assign out_o.tag_number     = res_s.tag_number;
  assign out_o.tag_octets     = res_s.tag_octets;
  assign out_o.value_length   = res_s.value_length;
  assign out_o.is_indefinite  = res_s.indef;
  assign out_o.encoded_length = res_s.encoded_length;
  assign out_o.fits_buffer    = res_s.fits;

  // a successful result always carries a parsed tag and a nonzero total
  a_ok_has_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && res_s.status == ST_OK |-> res_s.tag_octets != 2'd0
      && res_s.encoded_length != '0)
    else $error("success without tag or encoded length");

  // failures clear the length results
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && res_s.status != ST_OK |-> res_s.value_length == '0
      && res_s.encoded_length == '0 && !res_s.fits)
    else $error("failure result carries length data");

  // a rejected tag never reaches the length stage as parsed
  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_valid_s && !tag_data_s.tag_ok |-> tag_data_s.tag_octets == 2'd0
      && tag_data_s.status != ST_OK)
    else $error("unparsed tag with octet count or success status");

endmodule

`default_nettype wire
